### rtl/dpg_pkg.sv
// Shared package of the distance panning gain block.
// Holds register codes, reset values, fixed-point constants and the gain table.
// Depends on nothing.
package dpg_pkg;

   localparam int PAN_ORDER_DEFAULT = 5;

   typedef enum logic [2:0] {
      CSR_LEFT_X  = 3'd0,
      CSR_LEFT_Y  = 3'd1,
      CSR_LEFT_Z  = 3'd2,
      CSR_RIGHT_X = 3'd3,
      CSR_RIGHT_Y = 3'd4,
      CSR_RIGHT_Z = 3'd5
   } csr_index_type;

   localparam logic signed [15:0] LEFT_X_RESET  = -16'sd256;
   localparam logic signed [15:0] LEFT_Y_RESET  = 16'sd256;
   localparam logic signed [15:0] LEFT_Z_RESET  = 16'sd0;
   localparam logic signed [15:0] RIGHT_X_RESET = 16'sd256;
   localparam logic signed [15:0] RIGHT_Y_RESET = 16'sd256;
   localparam logic signed [15:0] RIGHT_Z_RESET = 16'sd0;

   // Q16 constants.
   localparam logic [16:0] ONE_Q16       = 17'd65536;
   localparam logic [16:0] HALF_Q16      = 17'd32768;
   localparam logic [16:0] INSIDE_GAIN   = 17'd60412;
   localparam logic [23:0] RADIUS_Q16    = 24'd92682;
   localparam logic [12:0] OCTAVES_PER_M = 13'd5443;
   localparam logic [31:0] INSIDE_LIMIT  = 32'd131072;

   // Q16 value of 2^-(2^-(pos+1)).
   function automatic logic [15:0] exp2_neg(input logic [3:0] pos);
      logic [15:0] val;
      case (pos)
         4'd0:  val = 16'd46341;
         4'd1:  val = 16'd55109;
         4'd2:  val = 16'd60097;
         4'd3:  val = 16'd62757;
         4'd4:  val = 16'd64132;
         4'd5:  val = 16'd64830;
         4'd6:  val = 16'd65182;
         4'd7:  val = 16'd65359;
         4'd8:  val = 16'd65447;
         4'd9:  val = 16'd65492;
         4'd10: val = 16'd65514;
         4'd11: val = 16'd65525;
         4'd12: val = 16'd65530;
         4'd13: val = 16'd65533;
         default: val = 16'd65535;
      endcase
      return val;
   endfunction

endpackage

### rtl/distance_panning_gain.sv
// Top level of the distance panning gain block.
// Uses dpg_pkg, dpg_sqrt_cell, dpg_div_cell and dpg_delay.
//
// Usage: each request word carries a source position (signed Q8.8 metres),
// a source index and a speaker select. Each accepted word gives exactly one
// response word with the echoed index and select, the source distance
// (unsigned Q8.8) and the panning gain for the chosen speaker (Q1.15).
// The six speaker coordinates are written through the csr port while no
// word is in flight; indexes above five are ignored.
//
// The datapath is a row of cells that each settle one bit or one factor:
// a 32-step square root for the source/speaker norm, a 17-step divider for
// the cosine term and PAN_ORDER multiply cells for its power, with the
// distance attenuation computed alongside. One word is accepted every cycle
// while the row is not held. When the receiver stalls a waiting response,
// the whole row holds and req_ready drops in the same cycle; it rises as soon
// as the response is taken. Reset clears all valid bits and restores the
// default speaker positions.
module distance_panning_gain #(
   parameter int PAN_ORDER = dpg_pkg::PAN_ORDER_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [3:0]         req_source_index,
   input  logic               req_speaker_select,
   input  logic signed [15:0] req_source_x,
   input  logic signed [15:0] req_source_y,
   input  logic signed [15:0] req_source_z,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [3:0]         rsp_result_source,
   output logic               rsp_result_speaker,
   output logic [15:0]        rsp_speaker_gain,
   output logic [15:0]        rsp_source_distance,
   input  logic               csr_wr_en,
   input  logic [2:0]         csr_index,
   input  logic [15:0]        csr_wdata
);

   // Chain lengths.
   localparam int DIST_STEPS = 16;
   localparam int EXT_STEPS  = 24;
   localparam int NORM_STEPS = 32;
   localparam int QUO_W      = 17;
   localparam int EXP_STEPS  = 16;

   // Stage numbers, counted from the register loaded at acceptance (stage 1).
   localparam int SQ_STAGE   = 3;
   localparam int DG_STAGE   = SQ_STAGE + EXT_STEPS + 2 + EXP_STEPS + 1;
   localparam int DIV_DONE   = SQ_STAGE + NORM_STEPS + 1 + QUO_W;
   localparam int POW_DONE   = DIV_DONE + PAN_ORDER;
   localparam int LATENCY    = POW_DONE + 1;

   localparam int DOT_DELAY    = NORM_STEPS;
   localparam int ZERO_DELAY   = DIV_DONE - SQ_STAGE;
   localparam int INSIDE_DELAY = DG_STAGE - 1 - SQ_STAGE;
   localparam int TAG_DELAY    = POW_DONE - SQ_STAGE;
   localparam int DIST_DELAY   = POW_DONE - SQ_STAGE - DIST_STEPS;
   localparam int DG_DELAY     = POW_DONE - DG_STAGE;

   // ---------------------------------------------------------------------
   // Speaker position registers.
   // ---------------------------------------------------------------------
   logic signed [15:0] left_x_ff, left_y_ff, left_z_ff;
   logic signed [15:0] right_x_ff, right_y_ff, right_z_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         left_x_ff  <= dpg_pkg::LEFT_X_RESET;
         left_y_ff  <= dpg_pkg::LEFT_Y_RESET;
         left_z_ff  <= dpg_pkg::LEFT_Z_RESET;
         right_x_ff <= dpg_pkg::RIGHT_X_RESET;
         right_y_ff <= dpg_pkg::RIGHT_Y_RESET;
         right_z_ff <= dpg_pkg::RIGHT_Z_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            dpg_pkg::CSR_LEFT_X:  left_x_ff  <= $signed(csr_wdata);
            dpg_pkg::CSR_LEFT_Y:  left_y_ff  <= $signed(csr_wdata);
            dpg_pkg::CSR_LEFT_Z:  left_z_ff  <= $signed(csr_wdata);
            dpg_pkg::CSR_RIGHT_X: right_x_ff <= $signed(csr_wdata);
            dpg_pkg::CSR_RIGHT_Y: right_y_ff <= $signed(csr_wdata);
            dpg_pkg::CSR_RIGHT_Z: right_z_ff <= $signed(csr_wdata);
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Flow control: the whole row advances unless a response is held.
   // ---------------------------------------------------------------------
   logic               en;
   logic [LATENCY-1:0] valid_ff;

   assign en        = !valid_ff[LATENCY-1] || rsp_ready;
   assign req_ready = en;
   assign rsp_valid = valid_ff[LATENCY-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[LATENCY-2:0], req_valid};
      end
   end

   // ---------------------------------------------------------------------
   // Stage 1: all products of source and speaker coordinates.
   // ---------------------------------------------------------------------
   logic signed [15:0] px, py, pz;
   logic signed [31:0] xx_full, yy_full, zz_full;
   logic signed [31:0] pxx_full, pyy_full, pzz_full;
   logic [30:0]        xx_ff, yy_ff, zz_ff, pxx_ff, pyy_ff, pzz_ff;
   logic signed [31:0] dx_ff, dy_ff, dz_ff;
   logic [4:0]         tag1_ff;

   always_comb begin
      px       = req_speaker_select ? right_x_ff : left_x_ff;
      py       = req_speaker_select ? right_y_ff : left_y_ff;
      pz       = req_speaker_select ? right_z_ff : left_z_ff;
      xx_full  = req_source_x * req_source_x;
      yy_full  = req_source_y * req_source_y;
      zz_full  = req_source_z * req_source_z;
      pxx_full = px * px;
      pyy_full = py * py;
      pzz_full = pz * pz;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         xx_ff   <= xx_full[30:0];
         yy_ff   <= yy_full[30:0];
         zz_ff   <= zz_full[30:0];
         pxx_ff  <= pxx_full[30:0];
         pyy_ff  <= pyy_full[30:0];
         pzz_ff  <= pzz_full[30:0];
         dx_ff   <= req_source_x * px;
         dy_ff   <= req_source_y * py;
         dz_ff   <= req_source_z * pz;
         tag1_ff <= {req_source_index, req_speaker_select};
      end
   end

   // Stage 2: squared lengths and dot product.
   logic [31:0]        ss_ff, sp_ff;
   logic signed [33:0] dot_ff;
   logic [4:0]         tag2_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         ss_ff   <= 32'(xx_ff) + 32'(yy_ff) + 32'(zz_ff);
         sp_ff   <= 32'(pxx_ff) + 32'(pyy_ff) + 32'(pzz_ff);
         dot_ff  <= 34'(dx_ff) + 34'(dy_ff) + 34'(dz_ff);
         tag2_ff <= tag1_ff;
      end
   end

   // Stage 3: product of the squared lengths and the origin test.
   logic [63:0]        prod_ff;
   logic               zero_ff;
   logic [31:0]        ss3_ff;
   logic signed [33:0] dot3_ff;
   logic [4:0]         tag3_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= 64'(ss_ff) * 64'(sp_ff);
         zero_ff <= (ss_ff == '0) || (sp_ff == '0);
         ss3_ff  <= ss_ff;
         dot3_ff <= dot_ff;
         tag3_ff <= tag2_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Square root chains: distance, distance in Q16, and the norm product.
   // ---------------------------------------------------------------------
   logic [31:0] dist_rem  [DIST_STEPS+1];
   logic [31:0] dist_root [DIST_STEPS+1];
   logic [47:0] ext_rem   [EXT_STEPS+1];
   logic [47:0] ext_root  [EXT_STEPS+1];
   logic [63:0] norm_rem  [NORM_STEPS+1];
   logic [63:0] norm_root [NORM_STEPS+1];

   assign dist_rem[0]  = ss3_ff;
   assign dist_root[0] = '0;
   assign ext_rem[0]   = {ss3_ff, 16'd0};
   assign ext_root[0]  = '0;
   assign norm_rem[0]  = prod_ff;
   assign norm_root[0] = '0;

   for (genvar k = 0; k < DIST_STEPS; k++) begin : g_dist
      dpg_sqrt_cell #(.WIDTH(32), .STEP(k)) u_cell (
         .clock(clock), .en(en),
         .rem_up(dist_rem[k]), .root_up(dist_root[k]),
         .rem_ff(dist_rem[k+1]), .root_ff(dist_root[k+1])
      );
   end

   for (genvar k = 0; k < EXT_STEPS; k++) begin : g_ext
      dpg_sqrt_cell #(.WIDTH(48), .STEP(k)) u_cell (
         .clock(clock), .en(en),
         .rem_up(ext_rem[k]), .root_up(ext_root[k]),
         .rem_ff(ext_rem[k+1]), .root_ff(ext_root[k+1])
      );
   end

   for (genvar k = 0; k < NORM_STEPS; k++) begin : g_norm
      dpg_sqrt_cell #(.WIDTH(64), .STEP(k)) u_cell (
         .clock(clock), .en(en),
         .rem_up(norm_rem[k]), .root_up(norm_root[k]),
         .rem_ff(norm_rem[k+1]), .root_ff(norm_root[k+1])
      );
   end

   // ---------------------------------------------------------------------
   // Distance attenuation: excess over the center radius, converted to
   // octaves, then one cell per fractional bit multiplies in 2^-weight.
   // ---------------------------------------------------------------------
   logic [23:0] ext_val;
   logic [23:0] excess_ff;
   logic [36:0] oct_full;
   logic [15:0] oct_frac_ff;
   logic [4:0]  oct_int_ff;

   assign ext_val  = ext_root[EXT_STEPS][23:0];
   assign oct_full = 37'(excess_ff) * 37'(dpg_pkg::OCTAVES_PER_M);

   always_ff @(posedge clock) begin
      if (en) begin
         excess_ff   <= (ext_val >= dpg_pkg::RADIUS_Q16) ?
                        ext_val - dpg_pkg::RADIUS_Q16 : '0;
         oct_frac_ff <= oct_full[31:16];
         oct_int_ff  <= oct_full[36:32];
      end
   end

   logic [16:0] exp_v [EXP_STEPS+1];
   logic [15:0] exp_f [EXP_STEPS+1];
   logic [4:0]  exp_n [EXP_STEPS+1];

   assign exp_v[0] = dpg_pkg::ONE_Q16;
   assign exp_f[0] = oct_frac_ff;
   assign exp_n[0] = oct_int_ff;

   for (genvar i = 0; i < EXP_STEPS; i++) begin : g_exp
      logic [32:0] mul;
      assign mul = 33'(exp_v[i]) * 33'(dpg_pkg::exp2_neg(4'(i)));
      always_ff @(posedge clock) begin
         if (en) begin
            exp_v[i+1] <= exp_f[i][EXP_STEPS-1-i] ?
                          17'((mul + 33'(dpg_pkg::HALF_Q16)) >> 16) : exp_v[i];
            exp_f[i+1] <= exp_f[i];
            exp_n[i+1] <= exp_n[i];
         end
      end
   end

   // Inside the center radius the attenuation is a fixed value.
   logic        inside_late;
   logic [16:0] dg_ff;

   dpg_delay #(.WIDTH(1), .DEPTH(INSIDE_DELAY)) u_inside_dly (
      .clock(clock), .en(en),
      .data_up(ss3_ff < dpg_pkg::INSIDE_LIMIT), .data_out(inside_late)
   );

   always_ff @(posedge clock) begin
      if (en) begin
         if (inside_late) begin
            dg_ff <= dpg_pkg::INSIDE_GAIN;
         end else if (exp_n[EXP_STEPS] >= 5'd17) begin
            dg_ff <= '0;
         end else begin
            dg_ff <= exp_v[EXP_STEPS] >> exp_n[EXP_STEPS];
         end
      end
   end

   // ---------------------------------------------------------------------
   // Directional factor: clamp dot + norm, divide by twice the norm.
   // ---------------------------------------------------------------------
   logic [33:0]        dot_late_bits;
   logic signed [33:0] dot_late;
   logic [31:0]        norm_val;
   logic signed [34:0] num_s;
   logic [32:0]        limit;
   logic [32:0]        num_c;

   dpg_delay #(.WIDTH(34), .DEPTH(DOT_DELAY)) u_dot_dly (
      .clock(clock), .en(en), .data_up(dot3_ff), .data_out(dot_late_bits)
   );

   always_comb begin
      dot_late = $signed(dot_late_bits);
      norm_val = norm_root[NORM_STEPS][31:0];
      limit    = {norm_val, 1'b0};
      num_s    = 35'(dot_late) + $signed({3'b000, norm_val});
      if (num_s < 0) begin
         num_c = '0;
      end else if (num_s > $signed({2'b00, limit})) begin
         num_c = limit;
      end else begin
         num_c = num_s[32:0];
      end
   end

   logic [49:0]      div_rem [QUO_W+1];
   logic [32:0]      div_d   [QUO_W+1];
   logic [QUO_W-1:0] div_q   [QUO_W+1];

   always_ff @(posedge clock) begin
      if (en) begin
         div_rem[0] <= 50'({num_c, 16'd0}) + 50'(norm_val);
         div_d[0]   <= limit;
      end
   end

   assign div_q[0] = '0;

   for (genvar k = 0; k < QUO_W; k++) begin : g_div
      dpg_div_cell #(.REM_W(50), .DIV_W(33), .QUO_W(QUO_W), .STEP(QUO_W-1-k)) u_cell (
         .clock(clock), .en(en),
         .rem_up(div_rem[k]), .div_up(div_d[k]), .quo_up(div_q[k]),
         .rem_ff(div_rem[k+1]), .div_ff(div_d[k+1]), .quo_ff(div_q[k+1])
      );
   end

   // A source or speaker at the origin gives a cosine of zero.
   logic zero_late;

   dpg_delay #(.WIDTH(1), .DEPTH(ZERO_DELAY)) u_zero_dly (
      .clock(clock), .en(en), .data_up(zero_ff), .data_out(zero_late)
   );

   logic [16:0] pow_hp [PAN_ORDER+1];
   logic [16:0] pow_h  [PAN_ORDER+1];

   assign pow_hp[0] = dpg_pkg::ONE_Q16;
   assign pow_h[0]  = zero_late ? dpg_pkg::HALF_Q16 : div_q[QUO_W];

   for (genvar k = 0; k < PAN_ORDER; k++) begin : g_pow
      logic [33:0] mul;
      assign mul = 34'(pow_hp[k]) * 34'(pow_h[k]);
      always_ff @(posedge clock) begin
         if (en) begin
            pow_hp[k+1] <= 17'((mul + 34'(dpg_pkg::HALF_Q16)) >> 16);
            pow_h[k+1]  <= pow_h[k];
         end
      end
   end

   // ---------------------------------------------------------------------
   // Alignment of the side data and the output register.
   // ---------------------------------------------------------------------
   logic [4:0]  tag_late;
   logic [15:0] dist_late;
   logic [16:0] dg_late;

   dpg_delay #(.WIDTH(5), .DEPTH(TAG_DELAY)) u_tag_dly (
      .clock(clock), .en(en), .data_up(tag3_ff), .data_out(tag_late)
   );

   // The root of a 32-bit sum of three squares never exceeds 16 bits.
   dpg_delay #(.WIDTH(16), .DEPTH(DIST_DELAY)) u_dist_dly (
      .clock(clock), .en(en),
      .data_up(dist_root[DIST_STEPS][15:0]), .data_out(dist_late)
   );

   dpg_delay #(.WIDTH(17), .DEPTH(DG_DELAY)) u_dg_dly (
      .clock(clock), .en(en), .data_up(dg_ff), .data_out(dg_late)
   );

   logic [33:0] gain_full;
   logic [33:0] gain_rnd;
   logic [3:0]  source_ff;
   logic        speaker_ff;
   logic [15:0] gain_ff;
   logic [15:0] distance_ff;

   assign gain_full = 34'(dg_late) * 34'(pow_hp[PAN_ORDER]);
   assign gain_rnd  = (gain_full + 34'(dpg_pkg::ONE_Q16)) >> 17;

   always_ff @(posedge clock) begin
      if (en) begin
         source_ff   <= tag_late[4:1];
         speaker_ff  <= tag_late[0];
         gain_ff     <= gain_rnd[15:0];
         distance_ff <= dist_late;
      end
   end

   assign rsp_result_source   = source_ff;
   assign rsp_result_speaker  = speaker_ff;
   assign rsp_speaker_gain    = gain_ff;
   assign rsp_source_distance = distance_ff;

`ifndef SYNTH
   // The divider quotient stays within 1.0 for every real direction.
   a_quo_range: assert property (@(posedge clock) disable iff (reset)
      valid_ff[DIV_DONE-1] && !zero_late |-> div_q[QUO_W] <= 17'd65536)
      else $error("direction quotient above 1.0");

   a_pow_range: assert property (@(posedge clock) disable iff (reset)
      valid_ff[POW_DONE-1] |-> pow_hp[PAN_ORDER] <= 17'd65536)
      else $error("directional power above 1.0");

   a_dg_range: assert property (@(posedge clock) disable iff (reset)
      valid_ff[DG_STAGE-1] |-> dg_ff <= 17'd65536)
      else $error("distance attenuation above 1.0");

   a_gain_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_speaker_gain <= 16'd32768)
      else $error("speaker gain above 1.0");
`endif

endmodule

### rtl/dpg_sqrt_cell.sv
// One step of a pipelined integer square root: settles one root bit.
// Stand-alone; chained by the top level.
module dpg_sqrt_cell #(
   parameter int WIDTH = 32,
   parameter int STEP  = 0
) (
   input  logic             clock,
   input  logic             en,
   input  logic [WIDTH-1:0] rem_up,
   input  logic [WIDTH-1:0] root_up,
   output logic [WIDTH-1:0] rem_ff,
   output logic [WIDTH-1:0] root_ff
);

   localparam logic [WIDTH-1:0] BIT = WIDTH'(1) << (WIDTH - 2 - 2 * STEP);

   logic [WIDTH-1:0] trial;
   logic [WIDTH-1:0] rem_in;
   logic [WIDTH-1:0] root_in;

   always_comb begin
      trial = root_up + BIT;
      if (rem_up >= trial) begin
         rem_in  = rem_up - trial;
         root_in = (root_up >> 1) + BIT;
      end else begin
         rem_in  = rem_up;
         root_in = root_up >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff  <= rem_in;
         root_ff <= root_in;
      end
   end

endmodule

### rtl/dpg_div_cell.sv
// One step of a pipelined restoring divider: settles one quotient bit.
// Stand-alone; chained by the top level.
module dpg_div_cell #(
   parameter int REM_W = 50,
   parameter int DIV_W = 33,
   parameter int QUO_W = 17,
   parameter int STEP  = 0
) (
   input  logic             clock,
   input  logic             en,
   input  logic [REM_W-1:0] rem_up,
   input  logic [DIV_W-1:0] div_up,
   input  logic [QUO_W-1:0] quo_up,
   output logic [REM_W-1:0] rem_ff,
   output logic [DIV_W-1:0] div_ff,
   output logic [QUO_W-1:0] quo_ff
);

   logic [REM_W-1:0] shifted;
   logic [REM_W-1:0] rem_in;
   logic [QUO_W-1:0] quo_in;

   always_comb begin
      shifted = REM_W'(div_up) << STEP;
      if (rem_up >= shifted) begin
         rem_in = rem_up - shifted;
         quo_in = quo_up | (QUO_W'(1) << STEP);
      end else begin
         rem_in = rem_up;
         quo_in = quo_up;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff <= rem_in;
         div_ff <= div_up;
         quo_ff <= quo_in;
      end
   end

endmodule

### rtl/dpg_delay.sv
// Shift line that keeps side data in step with the arithmetic chains.
// Stand-alone; used by the top level.
module dpg_delay #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 1
) (
   input  logic             clock,
   input  logic             en,
   input  logic [WIDTH-1:0] data_up,
   output logic [WIDTH-1:0] data_out
);

   logic [WIDTH-1:0] line_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (en) begin
         line_ff[0] <= data_up;
         for (int i = 1; i < DEPTH; i++) begin
            line_ff[i] <= line_ff[i-1];
         end
      end
   end

   assign data_out = line_ff[DEPTH-1];

endmodule
